// ===== sv/brs_pkg.sv =====
// shared types and constants for the bitstream run statistics block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

	localparam int BYTE_W   = 8;
	localparam int BYTES_W  = 61;
	localparam int COUNT_W  = 64;
	localparam int SMALL_W  = 4;
	localparam int INNER_W  = 3;
	localparam int RESULT_W = BYTES_W + 7 * COUNT_W + 3;

	localparam logic [SMALL_W-1:0] BITS_PER_BYTE = SMALL_W'(BYTE_W);

	// summary of one byte, bits read msb first
	typedef struct packed {
		logic               msb;
		logic               lsb;
		logic [SMALL_W-1:0] ones;
		logic [SMALL_W-1:0] zeros;
		logic [INNER_W-1:0] inner_trans;
		logic [INNER_W-1:0] inner_pairs;
		logic [SMALL_W-1:0] lead_run;
		logic [SMALL_W-1:0] tail_run;
		logic [SMALL_W-1:0] max_run;
	} byte_scan_t;

	// running statistics as reported
	typedef struct packed {
		logic [BYTES_W-1:0] bytes;
		logic [COUNT_W-1:0] ones;
		logic [COUNT_W-1:0] zeros;
		logic [COUNT_W-1:0] trans;
		logic [COUNT_W-1:0] runs;
		logic [COUNT_W-1:0] best;
		logic [COUNT_W-1:0] now;
		logic [COUNT_W-1:0] pairs;
		logic               first;
		logic               last;
	} stats_t;

endpackage

`default_nettype wire

// ===== sv/bitstream_run_statistics.sv =====
// bitstream run statistics: one byte in, one counter snapshot out per transfer
// each byte passes the input register, then the result register; it waits in the
// input register while the result register is full and m_tready is low
// throughput: one byte per cycle with m_tready high; counter update in a single pass
// stalls: s_tready drops only while both registers are full and m_tready is low
// reset: arst_n clears all counters, run lengths, first/last bit and both valid flags
// a byte arriving when the byte count is full is dropped and reported with overflow set
// depends on brs_pkg, brs_byte_scan, brs_accum
`timescale 1ns / 1ps
`default_nettype none

module bitstream_run_statistics (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [brs_pkg::BYTE_W-1:0]    s_tdata,  // data_byte
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// from bit 0 up: byte_count, one_count, zero_count, transition_count,
	// run_count, best_run, current_run, adjacent_ones_pairs, first_bit,
	// last_bit, overflow
	output logic [brs_pkg::RESULT_W-1:0]       m_tdata
);
	import brs_pkg::*;

	// input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic              m_valid_q;
	stats_t            result_q;
	logic              overflow_q;

	// stage hand-off: s1 moves on whenever the result register is free or drains
	logic       advance;
	logic       commit;
	byte_scan_t scan;
	stats_t     stats_nxt;
	logic       drop;

	assign advance  = !m_valid_q || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// bit summary of the byte in s1
	brs_byte_scan u_scan (
		.data (byte_s1),
		.scan (scan)
	);

	// running counters, updated on commit unless the byte count is full
	brs_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.scan      (scan),
		.stats_nxt (stats_nxt),
		.drop      (drop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	// snapshot of the updated counters for the result transfer
	always_ff @(posedge clk) begin
		if (commit) begin
			result_q   <= stats_nxt;
			overflow_q <= drop;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {overflow_q,
	                   result_q.last,
	                   result_q.first,
	                   result_q.pairs,
	                   result_q.now,
	                   result_q.best,
	                   result_q.runs,
	                   result_q.trans,
	                   result_q.zeros,
	                   result_q.ones,
	                   result_q.bytes};

endmodule

`default_nettype wire

// ===== sv/brs_byte_scan.sv =====
// per-byte bit summary: popcount, inner transitions and pairs, run lengths
// depends on brs_pkg
`timescale 1ns / 1ps
`default_nettype none

module brs_byte_scan (
	input  wire logic [brs_pkg::BYTE_W-1:0] data,
	output brs_pkg::byte_scan_t             scan
);
	import brs_pkg::*;

	always_comb begin
		logic [SMALL_W-1:0] ones;
		logic [INNER_W-1:0] trans;
		logic [INNER_W-1:0] pairs;
		logic [SMALL_W-1:0] lead;
		logic [SMALL_W-1:0] tail;
		logic [SMALL_W-1:0] cur;
		logic [SMALL_W-1:0] mx;
		logic               lead_on;
		logic               tail_on;

		ones    = '0;
		trans   = '0;
		pairs   = '0;
		lead    = SMALL_W'(1);
		tail    = SMALL_W'(1);
		cur     = SMALL_W'(1);
		mx      = SMALL_W'(1);
		lead_on = 1'b1;
		tail_on = 1'b1;

		for (int i = 0; i < BYTE_W; i++) begin
			ones = ones + SMALL_W'(data[i]);
		end

		for (int i = 0; i < BYTE_W - 1; i++) begin
			trans = trans + INNER_W'(data[i+1] ^ data[i]);
			pairs = pairs + INNER_W'(data[i+1] & data[i]);
		end

		// leading run from the msb, trailing run from the lsb
		for (int i = BYTE_W - 2; i >= 0; i--) begin
			if (lead_on && (data[i] == data[BYTE_W-1])) begin
				lead = lead + SMALL_W'(1);
			end else begin
				lead_on = 1'b0;
			end
		end
		for (int i = 1; i < BYTE_W; i++) begin
			if (tail_on && (data[i] == data[0])) begin
				tail = tail + SMALL_W'(1);
			end else begin
				tail_on = 1'b0;
			end
		end

		// longest run inside the byte
		for (int i = BYTE_W - 2; i >= 0; i--) begin
			if (data[i] == data[i+1]) begin
				cur = cur + SMALL_W'(1);
			end else begin
				cur = SMALL_W'(1);
			end
			if (cur > mx) begin
				mx = cur;
			end
		end

		scan.msb         = data[BYTE_W-1];
		scan.lsb         = data[0];
		scan.ones        = ones;
		scan.zeros       = BITS_PER_BYTE - ones;
		scan.inner_trans = trans;
		scan.inner_pairs = pairs;
		scan.lead_run    = lead;
		scan.tail_run    = tail;
		scan.max_run     = mx;
	end

endmodule

`default_nettype wire

// ===== sv/brs_accum.sv =====
// running counters of the stream, updated by one byte summary per commit
// depends on brs_pkg; fed by brs_byte_scan
`timescale 1ns / 1ps
`default_nettype none

module brs_accum (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                commit,
	input  wire brs_pkg::byte_scan_t scan,
	output brs_pkg::stats_t          stats_nxt,
	output logic                     drop
);
	import brs_pkg::*;

	stats_t             stats_q;
	logic               have_q;
	logic               edge_trans;
	logic               edge_pair;
	logic               cont;
	logic [COUNT_W-1:0] lead_total;
	logic [COUNT_W-1:0] best_a;
	logic [COUNT_W-1:0] run_inc;

	assign drop = (stats_q.bytes == {BYTES_W{1'b1}});

	assign edge_trans = have_q & (stats_q.last ^ scan.msb);
	assign edge_pair  = have_q & stats_q.last & scan.msb;
	assign cont       = have_q & ~(stats_q.last ^ scan.msb);

	// run reaching into this byte from the msb side
	assign lead_total = cont ? stats_q.now + COUNT_W'(scan.lead_run)
	                         : COUNT_W'(scan.lead_run);
	assign best_a     = (lead_total > stats_q.best) ? lead_total : stats_q.best;

	// new runs: each inner transition, plus boundary change or stream start
	assign run_inc = COUNT_W'(scan.inner_trans) + COUNT_W'(have_q ? edge_trans : 1'b1);

	always_comb begin
		stats_nxt = stats_q;
		if (!drop) begin
			stats_nxt.bytes = stats_q.bytes + BYTES_W'(1);
			stats_nxt.ones  = stats_q.ones + COUNT_W'(scan.ones);
			stats_nxt.zeros = stats_q.zeros + COUNT_W'(scan.zeros);
			stats_nxt.trans = stats_q.trans + COUNT_W'(scan.inner_trans)
			                  + COUNT_W'(edge_trans);
			stats_nxt.runs  = stats_q.runs + run_inc;
			stats_nxt.pairs = stats_q.pairs + COUNT_W'(scan.inner_pairs)
			                  + COUNT_W'(edge_pair);
			stats_nxt.now   = (scan.lead_run == BITS_PER_BYTE) ? lead_total
			                                                    : COUNT_W'(scan.tail_run);
			stats_nxt.best  = (COUNT_W'(scan.max_run) > best_a) ? COUNT_W'(scan.max_run)
			                                                    : best_a;
			stats_nxt.first = have_q ? stats_q.first : scan.msb;
			stats_nxt.last  = scan.lsb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
			have_q  <= 1'b0;
		end else if (commit && !drop) begin
			stats_q <= stats_nxt;
			have_q  <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_bitstream_run_statistics.sv =====
// self-checking bench for bitstream_run_statistics: directed byte table, then shaped random bytes
// expected snapshots: typed table rows, else a bit-serial tally; depends on brs_pkg and the rtl
`timescale 1ns / 1ps

module tb_bitstream_run_statistics;

	import brs_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 1200;
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_ERRORS  = 10;

	// result fields, last declared member lands in the lowest bits of tdata
	typedef struct packed {
		logic               overflow;
		logic               last_bit;
		logic               first_bit;
		logic [COUNT_W-1:0] adjacent_ones_pairs;
		logic [COUNT_W-1:0] current_run;
		logic [COUNT_W-1:0] best_run;
		logic [COUNT_W-1:0] run_count;
		logic [COUNT_W-1:0] transition_count;
		logic [COUNT_W-1:0] zero_count;
		logic [COUNT_W-1:0] one_count;
		logic [BYTES_W-1:0] byte_count;
	} snap_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              typed;
		snap_t             want;
	} row_t;

	typedef enum logic [1:0] {
		ALWAYS_READY,
		COIN_FLIP,
		ROTATING_MASK,
		MOSTLY_STALLED
	} stall_mode_t;

	// directed table: a leading one bit, then runs of all zeros and all ones,
	// alternating patterns, single set and clear bits, and a long zero run
	localparam int DIRECTED_ROWS = 23;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// first bit is one: a run of one, then seven zeros, no pair
		'{data: 8'h80, typed: 1'b1, want: '{byte_count: 1, one_count: 1, zero_count: 7,
			transition_count: 1, run_count: 2, best_run: 7, current_run: 7,
			adjacent_ones_pairs: 0, first_bit: 1, last_bit: 0, overflow: 0}},
		// zero run carries across the byte boundary
		'{data: 8'h00, typed: 1'b1, want: '{byte_count: 2, one_count: 1, zero_count: 15,
			transition_count: 1, run_count: 2, best_run: 15, current_run: 15,
			adjacent_ones_pairs: 0, first_bit: 1, last_bit: 0, overflow: 0}},
		'{data: 8'hFF, typed: 1'b1, want: '{byte_count: 3, one_count: 9, zero_count: 15,
			transition_count: 2, run_count: 3, best_run: 15, current_run: 8,
			adjacent_ones_pairs: 7, first_bit: 1, last_bit: 1, overflow: 0}},
		// one run overtakes the zero run, pair joins across the boundary
		'{data: 8'hFF, typed: 1'b1, want: '{byte_count: 4, one_count: 17, zero_count: 15,
			transition_count: 2, run_count: 3, best_run: 16, current_run: 16,
			adjacent_ones_pairs: 15, first_bit: 1, last_bit: 1, overflow: 0}},
		'{data: 8'h55, typed: 1'b0, want: '0},
		'{data: 8'hAA, typed: 1'b0, want: '0},
		'{data: 8'h01, typed: 1'b0, want: '0},
		'{data: 8'h7F, typed: 1'b0, want: '0},
		'{data: 8'hFE, typed: 1'b0, want: '0},
		'{data: 8'h0F, typed: 1'b0, want: '0},
		'{data: 8'hF0, typed: 1'b0, want: '0},
		'{data: 8'h33, typed: 1'b0, want: '0},
		'{data: 8'hCC, typed: 1'b0, want: '0},
		'{data: 8'h00, typed: 1'b0, want: '0},
		'{data: 8'h00, typed: 1'b0, want: '0},
		'{data: 8'h00, typed: 1'b0, want: '0},
		'{data: 8'h00, typed: 1'b0, want: '0},
		'{data: 8'hC3, typed: 1'b0, want: '0},
		'{data: 8'h3C, typed: 1'b0, want: '0},
		'{data: 8'h81, typed: 1'b0, want: '0},
		'{data: 8'h18, typed: 1'b0, want: '0},
		'{data: 8'h7E, typed: 1'b0, want: '0},
		'{data: 8'hE7, typed: 1'b0, want: '0}
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;   // data_byte
	logic                m_tvalid;
	logic                m_tready;
	// from bit 0 up: byte_count, one_count, zero_count, transition_count,
	// run_count, best_run, current_run, adjacent_ones_pairs, first_bit,
	// last_bit, overflow
	logic [RESULT_W-1:0] m_tdata;

	// running tally of the stream, advanced once per accepted byte
	logic [BYTES_W-1:0]  tally_bytes;
	logic [COUNT_W-1:0]  tally_ones;
	logic [COUNT_W-1:0]  tally_trans;
	logic [COUNT_W-1:0]  tally_pairs;
	logic [COUNT_W-1:0]  tally_run;
	logic [COUNT_W-1:0]  tally_best;
	logic                tally_lead;
	logic                tally_prev;
	logic                tally_started;

	snap_t               snapshot_q[$];
	int                  error_count;
	int                  result_index;
	int                  cycle_count;
	int                  burst_left;

	// receiver stall shaping
	stall_mode_t         stall_mode;
	int                  stall_left;
	logic [15:0]         ready_mask;

	bitstream_run_statistics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// fold one byte into the tally msb first and return the snapshot it leaves;
	// a full byte counter drops the byte and flags overflow
	function automatic snap_t tally_byte(input logic [BYTE_W-1:0] value);
		snap_t snap;
		logic  bit_in;
		logic  dropped;
		dropped = (tally_bytes == {BYTES_W{1'b1}});
		if (!dropped) begin
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				bit_in = value[i];
				tally_ones += COUNT_W'(bit_in);
				if (!tally_started) begin
					// the very first bit opens a run of one, nothing to pair with
					tally_started = 1'b1;
					tally_lead    = bit_in;
					tally_run     = COUNT_W'(1);
					tally_best    = COUNT_W'(1);
				end else begin
					if (tally_prev && bit_in)
						tally_pairs++;
					if (bit_in == tally_prev) begin
						tally_run++;
					end else begin
						tally_trans++;
						tally_run = COUNT_W'(1);
					end
					if (tally_run > tally_best)
						tally_best = tally_run;
				end
				tally_prev = bit_in;
			end
			tally_bytes++;
		end
		snap.byte_count          = tally_bytes;
		snap.one_count           = tally_ones;
		snap.zero_count          = (COUNT_W'(tally_bytes) << 3) - tally_ones;
		snap.transition_count    = tally_trans;
		snap.run_count           = tally_started ? tally_trans + COUNT_W'(1) : '0;
		snap.best_run            = tally_best;
		snap.current_run         = tally_run;
		snap.adjacent_ones_pairs = tally_pairs;
		snap.first_bit           = tally_lead;
		snap.last_bit            = tally_prev;
		snap.overflow            = dropped;
		return snap;
	endfunction

	// offer one byte, holding it until the transfer; bursts end in random gaps
	task automatic offer_byte(input logic [BYTE_W-1:0] value, input logic typed,
		input snap_t want);
		snap_t predicted;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = tally_byte(value);
		snapshot_q.push_back(typed ? want : predicted);
		burst_left--;
	endtask

	// hold the sender off until every expected snapshot has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (snapshot_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_field(input string name, input logic [COUNT_W-1:0] want,
		input logic [COUNT_W-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= SHOWN_ERRORS)
				$display("result %0d: %s expected %0d, got %0d",
					result_index, name, want, got);
		end
	endtask

	// stimulus
	initial begin : stimulus
		logic [BYTE_W-1:0] value;
		int                sent;
		int                kind;
		int                span;
		logic              drained_mid;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		burst_left = 0;
		sent        = 0;
		drained_mid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIRECTED_ROWS; r++)
			offer_byte(DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].want);
		drain_results();

		// random part, in segments that shape the bit stream
		while (sent < RANDOM_BYTES) begin
			kind = $urandom_range(0, 9);
			span = (kind <= 2) ? $urandom_range(1, 40) : $urandom_range(1, 20);
			for (int k = 0; k < span; k++) begin
				case (kind)
					// constant bytes build long runs of zeros or ones
					0, 1, 2: value = (kind == 0) ? 8'h00 : 8'hFF;
					// a single bit set or a single bit cleared
					6: value = 8'h01 << $urandom_range(0, 7);
					7: value = ~(8'h01 << $urandom_range(0, 7));
					// dense alternation, many transitions per byte
					8, 9: case ($urandom_range(0, 3))
						0: value = 8'h55;
						1: value = 8'hAA;
						2: value = 8'h33;
						default: value = 8'hCC;
					endcase
					default: value = BYTE_W'($urandom_range(0, 255));
				endcase
				offer_byte(value, 1'b0, '0);
				sent++;
			end
			// one full pause halfway through
			if (!drained_mid && sent >= RANDOM_BYTES / 2) begin
				drain_results();
				drained_mid = 1'b1;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && snapshot_q.size() == 0)
			$display("bitstream_run_statistics regression: pass");
		else
			$display("bitstream_run_statistics regression: fail");
		$finish;
	end

	// receiver: switches to a randomly chosen stall mode whenever stall_left runs out
	always @(posedge clk) begin
		if (stall_left <= 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
			ready_mask = 16'($urandom_range(1, 16'hFFFF));
		end
		stall_left--;
		ready_mask = {ready_mask[14:0], ready_mask[15]};
		case (stall_mode)
			ALWAYS_READY:  m_tready <= 1'b1;
			COIN_FLIP:     m_tready <= 1'($urandom_range(0, 1));
			ROTATING_MASK: m_tready <= ready_mask[0];
			default:       m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result checker: every transfer on the result side pops the oldest expectation
	always @(posedge clk) begin : result_check
		snap_t got;
		snap_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = snap_t'(m_tdata);
			if (snapshot_q.size() == 0) begin
				error_count++;
				if (error_count <= SHOWN_ERRORS)
					$display("result %0d arrived with nothing outstanding", result_index);
			end else begin
				want = snapshot_q.pop_front();
				note_field("byte_count", COUNT_W'(want.byte_count), COUNT_W'(got.byte_count));
				note_field("one_count", want.one_count, got.one_count);
				note_field("zero_count", want.zero_count, got.zero_count);
				note_field("transition_count", want.transition_count, got.transition_count);
				note_field("run_count", want.run_count, got.run_count);
				note_field("best_run", want.best_run, got.best_run);
				note_field("current_run", want.current_run, got.current_run);
				note_field("adjacent_ones_pairs", want.adjacent_ones_pairs,
					got.adjacent_ones_pairs);
				note_field("first_bit", COUNT_W'(want.first_bit), COUNT_W'(got.first_bit));
				note_field("last_bit", COUNT_W'(want.last_bit), COUNT_W'(got.last_bit));
				note_field("overflow", COUNT_W'(want.overflow), COUNT_W'(got.overflow));
			end
			result_index++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bitstream_run_statistics regression: fail");
			$finish;
		end
	end

	initial begin
		tally_bytes   = '0;
		tally_ones    = '0;
		tally_trans   = '0;
		tally_pairs   = '0;
		tally_run     = '0;
		tally_best    = '0;
		tally_lead    = 1'b0;
		tally_prev    = 1'b0;
		tally_started = 1'b0;
		error_count   = 0;
		result_index  = 0;
		cycle_count   = 0;
		stall_left    = 0;
		stall_mode    = ALWAYS_READY;
		ready_mask    = 16'hFFFF;
	end

endmodule
